// ===== rtl/rcld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcld_pkg
// Shared constants for the repetition code letter decoder.
// ----------------------------------------------------------------------------
package rcld_pkg;

	localparam int unsigned SymbolW = 7;

	typedef logic [SymbolW-1:0] symbol_t;

	localparam symbol_t LetterA   = 7'd97;
	localparam symbol_t QueryChar = 7'd63;

endpackage
`default_nettype wire

// ===== rtl/repetition_code_letter_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// repetition_code_letter_decoder
// Majority decoder for a word of DATA_BITS groups of REPEAT repeated bits that
// maps the decoded index to a lower case ASCII letter, or to '?' on failure.
//
//   Channel   Ports                       Handshake
//   request   start, code_word            taken when start is high, busy low
//   result    valid, symbol, failed       valid high for one cycle, no stall
//
// A request taken at a clock edge passes through the input register and then
// the result register before its result shows on the ports.
// A new request can be taken at every edge; busy is always low.
// Reset clears the valid flags of both stages; payload registers are not reset.
// The receiver cannot stall, so every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module repetition_code_letter_decoder #(
	parameter int unsigned REPEAT     = 9,
	parameter int unsigned DATA_BITS  = 5,
	parameter int unsigned MAX_ERRORS = 4,
	parameter int unsigned SYMBOLS    = 26
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [REPEAT*DATA_BITS-1:0]   code_word,
	output logic                               valid,
	output rcld_pkg::symbol_t                  symbol,
	output logic                               failed
);

	import rcld_pkg::*;

	localparam int unsigned WordW = REPEAT * DATA_BITS;
	localparam int unsigned CntW  = $clog2(REPEAT + 1);
	localparam int unsigned ErrW  = $clog2(WordW + 1);

	logic [WordW-1:0]     code_s1;
	logic                 valid_s1;
	logic [DATA_BITS-1:0] index_c;
	logic [ErrW-1:0]      errors_c;
	logic                 ok_c;
	logic [SymbolW:0]     letter_c;
	symbol_t              symbol_q;
	logic                 failed_q;
	logic                 valid_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			code_s1 <= code_word;
		end
	end

	always_comb begin
		logic [CntW-1:0] ones;
		logic [CntW-1:0] zeros;
		index_c  = '0;
		errors_c = '0;
		for (int unsigned g = 0; g < DATA_BITS; g++) begin
			ones = '0;
			for (int unsigned j = 0; j < REPEAT; j++) begin
				ones = ones + CntW'(code_s1[g*REPEAT+j]);
			end
			zeros = CntW'(REPEAT) - ones;
			if (ones > zeros) begin
				index_c[g] = 1'b1;
				errors_c   = errors_c + ErrW'(zeros);
			end else begin
				errors_c   = errors_c + ErrW'(ones);
			end
		end
	end

	assign ok_c     = (32'(errors_c) <= MAX_ERRORS) && (32'(index_c) < SYMBOLS);
	assign letter_c = (SymbolW+1)'(LetterA) + (SymbolW+1)'(index_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			symbol_q <= ok_c ? letter_c[SymbolW-1:0] : QueryChar;
			failed_q <= !ok_c;
		end
	end

	assign valid  = valid_q;
	assign symbol = symbol_q;
	assign failed = failed_q;

`ifndef SYNTH
	// Every request taken produces a result after the input and result registers.
	a_request_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 valid)
		else $error("request did not produce a result");

	// A failed result always carries the question mark.
	a_failed_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && failed) |-> (symbol == QueryChar))
		else $error("failed result without question mark");

	// A decoded result is never the question mark; checked while SYMBOLS is at most 30.
	a_decoded_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !failed && SYMBOLS <= 30) |-> (symbol != QueryChar))
		else $error("decoded result shows question mark");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the repetition code letter decoder. A queue of
// received words, directed corner cases first and then noisy code words and
// raw noise, feeds a clocked driver with random gaps between requests. Each
// taken request is decoded by a local majority model, and a clocked monitor
// compares every result strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	import rcld_pkg::*;

	localparam int unsigned GroupBits  = 9;
	localparam int unsigned Groups     = 5;
	localparam int unsigned WordW      = GroupBits * Groups;
	localparam int unsigned MaxErrors  = 4;
	localparam int unsigned Letters    = 26;
	localparam int unsigned RandomWords = 600;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		symbol_t symbol;
		logic    failed;
	} letter_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	word_t            code_word = '0;
	logic             busy;
	logic             valid;
	symbol_t          symbol;
	logic             failed;

	word_t            word_queue[$];
	letter_t          expected_letters[$];
	int unsigned      gap_left = 0;
	int unsigned      error_count = 0;

	repetition_code_letter_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.code_word (code_word),
		.valid     (valid),
		.symbol    (symbol),
		.failed    (failed)
	);

	always #2 clk = ~clk;

	function automatic letter_t predict_letter(input word_t w);
		letter_t     r;
		int unsigned ones;
		int unsigned index;
		int unsigned errs;
		index = 0;
		errs  = 0;
		for (int g = 0; g < Groups; g++) begin
			ones = 0;
			for (int j = 0; j < GroupBits; j++) begin
				ones += w[g*GroupBits + j];
			end
			if (ones > GroupBits - ones) begin
				index |= 1 << g;
				errs  += GroupBits - ones;
			end else begin
				errs  += ones;
			end
		end
		if (errs <= MaxErrors && index < Letters) begin
			r.symbol = symbol_t'(LetterA + index);
			r.failed = 1'b0;
		end else begin
			r.symbol = QueryChar;
			r.failed = 1'b1;
		end
		return r;
	endfunction

	function automatic word_t encode_letter(input int unsigned index);
		word_t w;
		w = '0;
		for (int g = 0; g < Groups; g++) begin
			if (index[g]) begin
				w[g*GroupBits +: GroupBits] = '1;
			end
		end
		return w;
	endfunction

	function automatic word_t flip_bits(input word_t w, input int unsigned count);
		word_t       mask;
		int unsigned pos;
		mask = '0;
		while ($countones(mask) < count) begin
			pos = $urandom_range(0, WordW - 1);
			mask[pos] = 1'b1;
		end
		return w ^ mask;
	endfunction

	function automatic int unsigned draw_gap();
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			code_word <= '0;
			gap_left  <= 0;
		end else begin
			if (start && !busy) begin
				expected_letters.push_back(predict_letter(code_word));
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (word_queue.size() != 0) begin
				start     <= 1'b1;
				code_word <= word_queue.pop_front();
				gap_left  <= draw_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		letter_t want;
		if (arst_n && valid) begin
			if (expected_letters.size() == 0) begin
				$display("%0t result with no request waiting: symbol %0d failed %0b",
					$time, symbol, failed);
				error_count++;
			end else begin
				want = expected_letters.pop_front();
				if (symbol !== want.symbol) begin
					report_mismatch("symbol", int'(symbol), int'(want.symbol));
				end
				if (failed !== want.failed) begin
					report_mismatch("failed", int'(failed), int'(want.failed));
				end
			end
		end
	end

	initial begin
		int unsigned index;
		word_t       noise;

		// Clean letters at both ends, indexes past the alphabet and the extremes.
		word_queue.push_back(encode_letter(0));
		word_queue.push_back(encode_letter(25));
		word_queue.push_back(encode_letter(26));
		word_queue.push_back(encode_letter(31));
		word_queue.push_back('1);
		word_queue.push_back(word_t'(45'h0AAA_AAAA_AAAA));
		word_queue.push_back(word_t'(45'h1555_5555_5555));
		// Four and five flips inside one group.
		word_queue.push_back(word_t'(45'hF));
		word_queue.push_back(word_t'(45'h1F));
		word_queue.push_back(encode_letter(25) ^ word_t'(45'h1E0));
		// Errors spread over the groups: exactly the limit, then one more.
		word_queue.push_back(encode_letter(25) ^ word_t'(45'h0_0804_0201));
		word_queue.push_back(encode_letter(25) ^ word_t'(45'h10_0804_0201));
		word_queue.push_back(encode_letter(12) ^ word_t'(45'h0_0804_0201));
		word_queue.push_back(encode_letter(12) ^ word_t'(45'h10_0804_0201));
		word_queue.push_back(flip_bits(encode_letter(7), 4));
		word_queue.push_back(flip_bits(encode_letter(19), 5));

		for (int n = 0; n < RandomWords; n++) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 7) == 0) begin
					index = $urandom_range(Letters, 31);
				end else begin
					index = $urandom_range(0, Letters - 1);
				end
				word_queue.push_back(flip_bits(encode_letter(index), $urandom_range(0, 6)));
			end else begin
				noise = word_t'({$urandom(), $urandom()});
				word_queue.push_back(noise);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_letters.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
`default_nettype wire
